// File: sv/gmdfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmdfs_pkg
// shared types and constants of the grid maze reachability search block
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    // grid side used when the top level is not told otherwise
    localparam int DEFAULT_GRID_SIDE = 16;

    // width of the search tag kept per cell in the visited memory
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // cell kinds
    localparam logic [1:0] KIND_WALL = 2'd0;
    localparam logic [1:0] KIND_GOAL = 2'd2;

    // neighbour directions in the order they are tried, then the end marker
    localparam logic [2:0] DIR_DOWN  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_CHECK,
        ST_POP
    } state_t;

endpackage
`default_nettype wire

// File: sv/grid_maze_dfs_reachability.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_maze_dfs_reachability
// depth-first reachability search over a loaded square grid maze
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low. cmd selects a load
//   of one grid cell (col, row, cell_value) or a search from (col, row).
//   a load finishes in the cycle it is taken and gives no result; busy stays
//   low, so loads can be issued every cycle.
//   a search answers with one result: done is high for exactly one cycle and
//   found is valid in that cycle. the receiver cannot stall, so the result
//   is simply dropped if nobody looks.
//   a search from outside the grid answers in the next cycle with found low.
//   otherwise a search checks the start cell and then, per cell it enters,
//   makes up to 4 neighbour probes, each reading the registered grid and
//   visited memories, and one pop, which reads the registered stack memory.
//   the search stops as soon as a goal cell is entered.
// reset
//   the visited memory holds a search tag per cell; after reset, and after
//   every 255th search from inside the grid, a clearing pass writes all
//   tags to zero, with busy high. grid contents are undefined until
//   loaded; every cell a search can reach must be loaded first.
// ----------------------------------------------------------------------------
module grid_maze_dfs_reachability #(
    parameter int GRID_SIDE = gmdfs_pkg::DEFAULT_GRID_SIDE
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       cmd,
    input  wire logic [3:0] col,
    input  wire logic [3:0] row,
    input  wire logic [1:0] cell_value,
    output logic            done,
    output logic            found
);

    // sizes
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW    = $clog2(GRID_SIDE);       // coordinate width
    localparam int AW    = $clog2(CELLS);           // cell address width
    localparam int SW    = 2 * CW + 2;              // stack entry: row, col, dir
    localparam int EW    = gmdfs_pkg::EPOCH_W;

    localparam logic [AW-1:0] SIDE_A    = AW'(GRID_SIDE);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);
    localparam logic [CW-1:0] SIDE_LAST = CW'(GRID_SIDE - 1);

    // row-major cell address
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * SIDE_A + AW'(c));
    endfunction

    // control and search registers
    gmdfs_pkg::state_t state_reg, state_next;
    logic [AW-1:0] sp_reg, sp_next;            // stack depth
    logic [EW-1:0] epoch_reg, epoch_next;      // tag of the running search
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;  // clearing pass address
    logic [2:0]    dir_reg, dir_next;          // next direction to try
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [CW-1:0] cur_row_reg, cur_row_next;
    logic          done_reg, done_next;
    logic          found_reg, found_next;

    // memories and their registered read data
    logic [1:0]    grid_mem  [CELLS];
    logic [EW-1:0] vis_mem   [CELLS];
    logic [SW-1:0] stack_mem [CELLS];
    logic [1:0]    grid_rd_reg;
    logic [EW-1:0] vis_rd_reg;
    logic [SW-1:0] stk_rd_reg;

    // memory ports
    logic          grid_we;
    logic [AW-1:0] grid_waddr;
    logic [AW-1:0] grid_raddr;
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic [EW-1:0] vis_wdata;
    logic          stk_we;
    logic [AW-1:0] stk_raddr;

    // derived signals
    logic          accept;
    logic          start_inside;
    logic [CW-1:0] start_col;
    logic [CW-1:0] start_row;
    logic [AW-1:0] start_addr;
    logic          nb_in;
    logic [CW-1:0] nb_col;
    logic [CW-1:0] nb_row;
    logic [AW-1:0] nb_addr;
    logic          nb_free;
    logic          stk_empty;
    gmdfs_pkg::state_t fin_state;

    assign accept       = start && !busy;
    assign start_inside = (32'(col) < GRID_SIDE) && (32'(row) < GRID_SIDE);
    assign start_col    = CW'(col);
    assign start_row    = CW'(row);
    assign start_addr   = cell_addr(start_row, start_col);
    assign nb_addr      = cell_addr(nb_row, nb_col);
    assign nb_free      = (grid_rd_reg != gmdfs_pkg::KIND_WALL) && (vis_rd_reg != epoch_reg);
    assign stk_empty    = (sp_reg == '0);
    // after the last tag value the visited memory is swept before reuse
    assign fin_state    = (epoch_reg == gmdfs_pkg::EPOCH_LAST) ? gmdfs_pkg::ST_CLEAR
                                                               : gmdfs_pkg::ST_IDLE;

    // neighbour of the current cell in the current direction
    always_comb
    begin
        nb_col = cur_col_reg;
        nb_row = cur_row_reg;
        nb_in  = 1'b0;
        case (dir_reg)
            gmdfs_pkg::DIR_DOWN:
            begin
                nb_in  = (cur_row_reg != SIDE_LAST);
                nb_row = cur_row_reg + CW'(1);
            end
            gmdfs_pkg::DIR_RIGHT:
            begin
                nb_in  = (cur_col_reg != SIDE_LAST);
                nb_col = cur_col_reg + CW'(1);
            end
            gmdfs_pkg::DIR_UP:
            begin
                nb_in  = (cur_row_reg != '0);
                nb_row = cur_row_reg - CW'(1);
            end
            gmdfs_pkg::DIR_LEFT:
            begin
                nb_in  = (cur_col_reg != '0);
                nb_col = cur_col_reg - CW'(1);
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmdfs_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_LAST)
                    state_next = gmdfs_pkg::ST_IDLE;
            end
            gmdfs_pkg::ST_IDLE:
            begin
                if (accept && cmd == gmdfs_pkg::CMD_SEARCH && start_inside)
                    state_next = gmdfs_pkg::ST_START;
            end
            gmdfs_pkg::ST_START:
            begin
                if (grid_rd_reg == gmdfs_pkg::KIND_WALL || grid_rd_reg == gmdfs_pkg::KIND_GOAL)
                    state_next = fin_state;
                else
                    state_next = gmdfs_pkg::ST_PROBE;
            end
            gmdfs_pkg::ST_PROBE:
            begin
                if (dir_reg == gmdfs_pkg::DIR_END)
                    state_next = stk_empty ? fin_state : gmdfs_pkg::ST_POP;
                else if (nb_in)
                    state_next = gmdfs_pkg::ST_CHECK;
            end
            gmdfs_pkg::ST_CHECK:
            begin
                if (nb_free && grid_rd_reg == gmdfs_pkg::KIND_GOAL)
                    state_next = fin_state;
                else
                    state_next = gmdfs_pkg::ST_PROBE;
            end
            gmdfs_pkg::ST_POP:
            begin
                state_next = gmdfs_pkg::ST_PROBE;
            end
            default:
            begin
                state_next = gmdfs_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        sp_next      = sp_reg;
        epoch_next   = epoch_reg;
        clr_cnt_next = clr_cnt_reg;
        dir_next     = dir_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        grid_we      = 1'b0;
        grid_waddr   = start_addr;
        grid_raddr   = nb_addr;
        vis_we       = 1'b0;
        vis_waddr    = nb_addr;
        vis_wdata    = epoch_reg;
        stk_we       = 1'b0;
        stk_raddr    = sp_reg - AW'(1);

        unique case (state_reg)
            gmdfs_pkg::ST_CLEAR:
            begin
                vis_we       = 1'b1;
                vis_waddr    = clr_cnt_reg;
                vis_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == ADDR_LAST)
                    epoch_next = gmdfs_pkg::EPOCH_FIRST;
            end
            gmdfs_pkg::ST_IDLE:
            begin
                grid_raddr = start_addr;
                if (accept)
                begin
                    if (cmd == gmdfs_pkg::CMD_LOAD)
                    begin
                        grid_we = start_inside;
                    end
                    else if (start_inside)
                    begin
                        // mark the start cell; a wall start ends before any probe
                        cur_col_next = start_col;
                        cur_row_next = start_row;
                        sp_next      = '0;
                        vis_we       = 1'b1;
                        vis_waddr    = start_addr;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                    end
                end
            end
            gmdfs_pkg::ST_START:
            begin
                dir_next = gmdfs_pkg::DIR_DOWN;
                if (grid_rd_reg == gmdfs_pkg::KIND_WALL || grid_rd_reg == gmdfs_pkg::KIND_GOAL)
                begin
                    done_next  = 1'b1;
                    found_next = (grid_rd_reg == gmdfs_pkg::KIND_GOAL);
                end
            end
            gmdfs_pkg::ST_PROBE:
            begin
                if (dir_reg == gmdfs_pkg::DIR_END)
                begin
                    if (stk_empty)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                    end
                    else
                    begin
                        sp_next = sp_reg - AW'(1);
                    end
                end
                else if (!nb_in)
                begin
                    dir_next = dir_reg + 3'd1;
                end
            end
            gmdfs_pkg::ST_CHECK:
            begin
                if (nb_free)
                begin
                    // step into the neighbour, remember where to resume here
                    stk_we       = 1'b1;
                    sp_next      = sp_reg + AW'(1);
                    vis_we       = 1'b1;
                    cur_col_next = nb_col;
                    cur_row_next = nb_row;
                    dir_next     = gmdfs_pkg::DIR_DOWN;
                    if (grid_rd_reg == gmdfs_pkg::KIND_GOAL)
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    dir_next = dir_reg + 3'd1;
                end
            end
            gmdfs_pkg::ST_POP:
            begin
                cur_row_next = stk_rd_reg[SW-1 -: CW];
                cur_col_next = stk_rd_reg[CW+1 -: CW];
                dir_next     = {1'b0, stk_rd_reg[1:0]} + 3'd1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        // tag roll-over at the end of a search
        if (done_next && state_reg != gmdfs_pkg::ST_IDLE)
        begin
            clr_cnt_next = '0;
            if (epoch_reg != gmdfs_pkg::EPOCH_LAST)
                epoch_next = epoch_reg + EW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gmdfs_pkg::ST_CLEAR;
            sp_reg      <= '0;
            epoch_reg   <= gmdfs_pkg::EPOCH_FIRST;
            clr_cnt_reg <= '0;
            dir_reg     <= gmdfs_pkg::DIR_DOWN;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            epoch_reg   <= epoch_next;
            clr_cnt_reg <= clr_cnt_next;
            dir_reg     <= dir_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_col_reg <= cur_col_next;
        cur_row_reg <= cur_row_next;
        found_reg   <= found_next;
    end

    // grid memory: written by loads, read by the search
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= cell_value;
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    // visited memory: one search tag per cell
    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rd_reg <= vis_mem[nb_addr];
    end

    // search stack: push at sp, pop reads sp - 1
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[sp_reg] <= {cur_row_reg, cur_col_reg, dir_reg[1:0]};
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    assign busy  = (state_reg != gmdfs_pkg::ST_IDLE);
    assign done  = done_reg;
    assign found = found_reg;

    // checks
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == gmdfs_pkg::ST_IDLE
                   || $past(state_reg) == gmdfs_pkg::ST_START
                   || $past(state_reg) == gmdfs_pkg::ST_PROBE
                   || $past(state_reg) == gmdfs_pkg::ST_CHECK))
        else $error("result strobe from a state that cannot finish a search");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (sp_reg != ADDR_LAST))
        else $error("stack push beyond the number of cells");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmdfs_pkg::ST_POP) |-> ($past(sp_reg) != '0))
        else $error("stack pop from an empty stack");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gmdfs_pkg::ST_START) |-> (epoch_reg != '0))
        else $error("search tag equals the cleared tag");

endmodule
`default_nettype wire

// File: dv/grid_maze_dfs_reachability_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_maze_dfs_reachability_tb
// self-checking bench for the grid maze reachability search block
// ----------------------------------------------------------------------------
// cells are loaded and searches are issued through the start/busy command
// port. a planner builds the whole item list up front and loads any cell
// that a search could read before that search is issued. a shadow maze
// updated on every accepted item works out the expected found bit, and the
// monitor compares each done strobe with the oldest outstanding search.
// stimulus: directed corner cases, a full serpentine walk, then random
// loads and searches with random idle gaps between items.
// ----------------------------------------------------------------------------
module grid_maze_dfs_reachability_tb;

    localparam int SIDE  = gmdfs_pkg::DEFAULT_GRID_SIDE;
    localparam int CELLS = SIDE * SIDE;

    // cell kinds that the package does not name
    localparam logic [1:0] KIND_OPEN = 2'd1;
    localparam logic [1:0] KIND_ODD  = 2'd3;

    localparam int ITEM_TARGET  = 1050;
    // worst case: ~1050 items, each a full-grid search plus the longest
    // gap and a share of the tag clearing pass, taken 4x over
    localparam int LIMIT_CYCLES = 12_000_000;
    // covers the longest single search
    localparam int TAIL_CYCLES  = 3000;

    typedef struct packed {
        logic       cmd;
        logic [3:0] col;
        logic [3:0] row;
        logic [1:0] kind;
        logic       drain;  // hold this item until every search has answered
    } maze_item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  col;
        logic [3:0]  row;
        int unsigned tag;
    } search_expect_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       start      = 1'b0;
    logic       cmd        = gmdfs_pkg::CMD_LOAD;
    logic [3:0] col        = '0;
    logic [3:0] row        = '0;
    logic [1:0] cell_value = gmdfs_pkg::KIND_WALL;
    logic       busy;
    logic       done;
    logic       found;

    // planner view of the maze, used only to keep searches off unloaded cells
    logic [1:0] plan_grid    [CELLS];
    bit         plan_written [CELLS];
    // shadow maze, updated on accepted items only
    logic [1:0] maze_grid    [CELLS];

    maze_item_t     pending_items[$];
    search_expect_t results_due[$];
    search_expect_t oldest_search;

    int idle_left     = 0;
    int quiet_left    = 0;
    int cycle_count   = 0;
    int fault_count   = 0;
    int loads_taken   = 0;
    int searches_seen = 0;
    int searches_sent = 0;
    int goals_found   = 0;

    grid_maze_dfs_reachability dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .col        (col),
        .row        (row),
        .cell_value (cell_value),
        .done       (done),
        .found      (found)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------------
    // shadow search
    // ------------------------------------------------------------------------

    function automatic logic [1:0] cell_kind(input bit from_plan, input int unsigned idx);
        return from_plan ? plan_grid[idx] : maze_grid[idx];
    endfunction

    function automatic int unsigned step(input int unsigned idx, input int d);
        case (d)
            gmdfs_pkg::DIR_DOWN:  return idx + SIDE;
            gmdfs_pkg::DIR_RIGHT: return idx + 1;
            gmdfs_pkg::DIR_UP:    return idx - SIDE;
            default:              return idx - 1;
        endcase
    endfunction

    // passable neighbours of a cell, one bit per direction code; miss gets the
    // first neighbour the planner has not loaded yet, or -1
    function automatic logic [3:0] open_dirs(input bit from_plan, input int unsigned idx,
                                             output int miss);
        int          d;
        int unsigned c;
        int unsigned r;
        int unsigned nb;
        bit          on_grid;
        logic [3:0]  mask;
        c    = idx % SIDE;
        r    = idx / SIDE;
        mask = '0;
        miss = -1;
        for (d = int'(gmdfs_pkg::DIR_DOWN); d <= int'(gmdfs_pkg::DIR_LEFT); d++)
        begin
            case (d)
                gmdfs_pkg::DIR_DOWN:  on_grid = r < SIDE - 1;
                gmdfs_pkg::DIR_RIGHT: on_grid = c < SIDE - 1;
                gmdfs_pkg::DIR_UP:    on_grid = r > 0;
                default:              on_grid = c > 0;
            endcase
            if (on_grid)
            begin
                nb = step(idx, d);
                if (from_plan && !plan_written[nb] && miss < 0)
                    miss = int'(nb);
                mask[d] = cell_kind(from_plan, nb) != gmdfs_pkg::KIND_WALL;
            end
        end
        return mask;
    endfunction

    // depth-first walk with an explicit trail; neighbours noted on entry and
    // tried down, right, up, left. backtracking to the start keeps going with
    // whatever the start cell still has left. hole reports an unloaded cell
    // that the walk would read (planner view only)
    function automatic bit goal_reachable(input bit from_plan, input int unsigned start_idx,
                                          output int hole);
        bit          seen       [CELLS];
        int unsigned trail_cell [CELLS];
        logic [3:0]  trail_dirs [CELLS];
        int unsigned depth;
        int unsigned here;
        int unsigned next;
        logic [3:0]  dirs;
        bit          moved;
        int          d;
        hole = -1;
        foreach (seen[i])
            seen[i] = 1'b0;
        depth = 0;
        here  = start_idx;
        next  = 0;
        if (from_plan && !plan_written[here])
        begin
            hole = int'(here);
            return 1'b0;
        end
        if (cell_kind(from_plan, here) == gmdfs_pkg::KIND_WALL)
            return 1'b0;
        seen[here] = 1'b1;
        dirs = open_dirs(from_plan, here, hole);
        if (hole >= 0)
            return 1'b0;
        while (1'b1)
        begin
            if (cell_kind(from_plan, here) == gmdfs_pkg::KIND_GOAL)
                return 1'b1;
            moved = 1'b0;
            for (d = int'(gmdfs_pkg::DIR_DOWN);
                 d <= int'(gmdfs_pkg::DIR_LEFT) && !moved; d++)
            begin
                if (dirs[d])
                begin
                    dirs[d] = 1'b0;
                    next    = step(here, d);
                    moved   = !seen[next];
                end
            end
            if (moved)
            begin
                trail_cell[depth] = here;
                trail_dirs[depth] = dirs;
                depth++;
                here       = next;
                seen[here] = 1'b1;
                dirs = open_dirs(from_plan, here, hole);
                if (hole >= 0)
                    return 1'b0;
            end
            else if (depth > 0)
            begin
                depth--;
                here = trail_cell[depth];
                dirs = trail_dirs[depth];
            end
            else
            begin
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // planning
    // ------------------------------------------------------------------------

    // mostly walls and open cells near the percolation point, few goals
    function automatic logic [1:0] random_kind();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return gmdfs_pkg::KIND_WALL;
        if (roll < 93)
            return KIND_OPEN;
        if (roll < 96)
            return gmdfs_pkg::KIND_GOAL;
        return KIND_ODD;
    endfunction

    task automatic plan_load(input int c, input int r, input logic [1:0] kind);
        maze_item_t item;
        item.cmd   = gmdfs_pkg::CMD_LOAD;
        item.col   = c[3:0];
        item.row   = r[3:0];
        item.kind  = kind;
        item.drain = 1'b0;
        pending_items = {pending_items, item};
        plan_grid[r * SIDE + c]    = kind;
        plan_written[r * SIDE + c] = 1'b1;
    endtask

    // any cell the walk would read is loaded with a random kind first
    task automatic plan_search(input int c, input int r, input bit drain);
        maze_item_t item;
        int         hole;
        void'(goal_reachable(1'b1, r * SIDE + c, hole));
        while (hole >= 0)
        begin
            plan_load(hole % SIDE, hole / SIDE, random_kind());
            void'(goal_reachable(1'b1, r * SIDE + c, hole));
        end
        item.cmd   = gmdfs_pkg::CMD_SEARCH;
        item.col   = c[3:0];
        item.row   = r[3:0];
        item.kind  = $urandom_range(3);
        item.drain = drain;
        pending_items = {pending_items, item};
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // shadow maze update and expectation for one accepted item
    task automatic take_item(input logic c_cmd, input logic [3:0] c_col,
                             input logic [3:0] c_row, input logic [1:0] c_kind);
        search_expect_t due;
        int             hole;
        if (c_cmd == gmdfs_pkg::CMD_LOAD)
        begin
            maze_grid[int'(c_row) * SIDE + int'(c_col)] = c_kind;
            loads_taken++;
        end
        else
        begin
            due.found = goal_reachable(1'b0, int'(c_row) * SIDE + int'(c_col), hole);
            due.col   = c_col;
            due.row   = c_row;
            due.tag   = searches_sent;
            results_due = {results_due, due};
            searches_sent++;
            if (due.found)
                goals_found++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: presents pending items, holds start while busy, idles at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= gmdfs_pkg::CMD_LOAD;
            col        <= '0;
            row        <= '0;
            cell_value <= gmdfs_pkg::KIND_WALL;
            idle_left  <= 0;
            quiet_left <= 0;
        end
        else
        begin
            if (start && !busy)
                take_item(cmd, col, row, cell_value);

            if (start && busy)
            begin
                // item not taken yet, keep it on the ports
            end
            else if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && results_due.size() != 0))
            begin
                start      <= 1'b1;
                cmd        <= pending_items[0].cmd;
                col        <= pending_items[0].col;
                row        <= pending_items[0].row;
                cell_value <= pending_items[0].kind;
                void'(pending_items.pop_front());
                // quiet stretches with back-to-back items, otherwise a gap
                // that is mostly short and now and then long
                if (quiet_left != 0)
                begin
                    quiet_left <= quiet_left - 1;
                    idle_left  <= 0;
                end
                else if ($urandom_range(99) < 2)
                begin
                    quiet_left <= $urandom_range(80, 20);
                    idle_left  <= 0;
                end
                else
                begin
                    case ($urandom_range(19))
                        0, 1, 2, 3, 4, 5, 6, 7: idle_left <= 0;
                        8, 9, 10, 11, 12, 13, 14, 15: idle_left <= $urandom_range(3, 1);
                        16, 17, 18: idle_left <= $urandom_range(12, 4);
                        default: idle_left <= $urandom_range(60, 20);
                    endcase
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every done strobe must match the oldest outstanding search
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (results_due.size() == 0)
            begin
                report_fault($sformatf("result found=%b with no search outstanding", found));
            end
            else
            begin
                oldest_search = results_due.pop_front();
                searches_seen++;
                if (found !== oldest_search.found)
                    report_fault($sformatf("search %0d from col %0d row %0d: found %b, expected %b",
                                           oldest_search.tag, oldest_search.col,
                                           oldest_search.row, found, oldest_search.found));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int         c;
        int         r;
        logic [1:0] k;

        foreach (plan_grid[i])
        begin
            plan_grid[i]    = gmdfs_pkg::KIND_WALL;
            plan_written[i] = 1'b0;
            maze_grid[i]    = gmdfs_pkg::KIND_WALL;
        end

        // wall start
        plan_load(0, 0, gmdfs_pkg::KIND_WALL);
        plan_search(0, 0, 1'b0);
        // goal start in the far corner
        plan_load(15, 15, gmdfs_pkg::KIND_GOAL);
        plan_search(15, 15, 1'b0);
        // kind three start boxed in by walls: open but not a goal
        plan_load(15, 0, KIND_ODD);
        plan_load(14, 0, gmdfs_pkg::KIND_WALL);
        plan_load(15, 1, gmdfs_pkg::KIND_WALL);
        plan_search(15, 0, 1'b0);
        // goal one step away on the bottom edge
        plan_load(0, 15, KIND_OPEN);
        plan_load(1, 15, gmdfs_pkg::KIND_GOAL);
        plan_load(0, 14, gmdfs_pkg::KIND_WALL);
        plan_search(0, 15, 1'b0);
        // dead end tried first, walk must come back to the start and go left
        plan_load(8, 8, KIND_OPEN);
        plan_load(8, 9, KIND_OPEN);
        plan_load(7, 9, gmdfs_pkg::KIND_WALL);
        plan_load(9, 9, gmdfs_pkg::KIND_WALL);
        plan_load(8, 10, gmdfs_pkg::KIND_WALL);
        plan_load(9, 8, gmdfs_pkg::KIND_WALL);
        plan_load(8, 7, gmdfs_pkg::KIND_WALL);
        plan_load(7, 8, gmdfs_pkg::KIND_GOAL);
        plan_search(8, 8, 1'b0);

        // serpentine through the whole grid, goal at the very end of the path
        for (r = 0; r < SIDE; r++)
        begin
            for (c = 0; c < SIDE; c++)
            begin
                if (r % 2 == 0)
                    k = KIND_OPEN;
                else if ((r % 4 == 1 && c == SIDE - 1) || (r % 4 == 3 && c == 0))
                    k = KIND_OPEN;
                else
                    k = gmdfs_pkg::KIND_WALL;
                if (r == SIDE - 1 && c == 0)
                    k = gmdfs_pkg::KIND_GOAL;
                plan_load(c, r, k);
            end
        end
        plan_search(0, 0, 1'b1);
        // goal removed: full walk, then from mid-path in both directions and from a wall
        plan_load(0, SIDE - 1, KIND_ODD);
        plan_search(0, 0, 1'b1);
        plan_search(7, 6, 1'b1);
        plan_search(15, 15, 1'b0);

        // random loads reshape the maze between random searches
        while (pending_items.size() < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 55)
                plan_search($urandom_range(SIDE - 1), $urandom_range(SIDE - 1),
                            $urandom_range(99) == 0);
            else
                plan_load($urandom_range(SIDE - 1), $urandom_range(SIDE - 1), random_kind());
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_items.size() != 0 || start || results_due.size() != 0) &&
               cycle_count < LIMIT_CYCLES)
            @(posedge clk);

        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles: %0d items unsent, %0d results outstanding",
                     cycle_count, pending_items.size(), results_due.size());
            $display("*** FAILED ***");
        end
        else
        begin
            // catch any stray strobe after the last answer
            repeat (TAIL_CYCLES) @(posedge clk);
            if (results_due.size() != 0)
                report_fault($sformatf("%0d searches never answered", results_due.size()));
            $display("covered %0d cell loads and %0d searches (%0d answered, %0d reaching a goal)",
                     loads_taken, searches_sent, searches_seen, goals_found);
            $display("wall/goal/odd-kind starts, serpentine full walks, random mazes; faults: %0d",
                     fault_count);
            if (fault_count == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
